### rtl/aes_pkg.sv
// Shared types, tables and round functions for the AES-128 encryption pipeline.
`timescale 1ns / 1ps
`default_nettype none

package aes_pkg;

   // Configuration register indexes
   localparam logic CSR_KEY_HI = 1'b0;
   localparam logic CSR_KEY_LO = 1'b1;

   // Round constants at the ends of the key schedule
   localparam logic [7:0] RCON_FIRST = 8'h01;
   localparam logic [7:0] RCON_LAST  = 8'h36;

   // Contents of one pipeline cell: cipher state, its round key, its round constant
   typedef struct packed {
      logic [127:0] state;
      logic [127:0] rkey;
      logic [7:0]   rcon;
   } stage_type;

   localparam logic [7:0] SBOX_TAB [0:255] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   // Multiply by x in GF(2^8)
   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // SubBytes and ShiftRows; byte 4*c+r sits at bits [127-8*(4*c+r) -: 8]
   function automatic logic [127:0] sub_shift(input logic [127:0] s);
      logic [127:0] t;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[127 - 8 * (4 * c + r) -: 8] =
               SBOX_TAB[s[127 - 8 * (4 * ((c + r) & 3) + r) -: 8]];
         end
      end
      return t;
   endfunction

   // MixColumns on all four columns
   function automatic logic [127:0] mix_cols(input logic [127:0] s);
      logic [127:0] t;
      logic [7:0]   a0, a1, a2, a3, all;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         a0  = s[127 - 32 * c -: 8];
         a1  = s[119 - 32 * c -: 8];
         a2  = s[111 - 32 * c -: 8];
         a3  = s[103 - 32 * c -: 8];
         all = a0 ^ a1 ^ a2 ^ a3;
         t[127 - 32 * c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
         t[119 - 32 * c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
         t[111 - 32 * c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
         t[103 - 32 * c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
      end
      return t;
   endfunction

   // One step of the key schedule: RotWord, SubWord, Rcon, then the word chain
   function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
      logic [31:0] sub_rot, w0, w1, w2, w3;
      sub_rot = {SBOX_TAB[k[23:16]] ^ rc, SBOX_TAB[k[15:8]],
                 SBOX_TAB[k[7:0]], SBOX_TAB[k[31:24]]};
      w0 = k[127:96] ^ sub_rot;
      w1 = k[95:64] ^ w0;
      w2 = k[63:32] ^ w1;
      w3 = k[31:0] ^ w2;
      return {w0, w1, w2, w3};
   endfunction

endpackage

`default_nettype wire

### rtl/aes128_block_encrypt.sv
// Top level of the AES-128 encryption pipeline: key registers, load cell, ten round cells.
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Contents
// req_     in         tdata[63:0] plain_hi, tdata[127:64] plain_lo
// rsp_     out        tdata[63:0] cipher_hi, tdata[127:64] cipher_lo
// csr_     in         write: index 0 key_hi, index 1 key_lo
//
// A block is accepted every cycle unless the pipeline is full and the output stalled; it
// passes the load cell (initial AddRoundKey) and then one cell per round for the ten rounds.
// Each cell stalls only when it is full and its neighbor is full and stalled, so bubbles
// close up and input keeps flowing while a finished result waits at the output.
// Reset is synchronous and clears the valid flags and the key to zero.
module aes128_block_encrypt (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [127:0] req_tdata,    // [63:0] plain_hi, [127:64] plain_lo
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [127:0] rsp_tdata,    // [63:0] cipher_hi, [127:64] cipher_lo
   input  wire          csr_we,
   input  wire          csr_addr,
   input  wire  [63:0]  csr_wdata
);

   localparam int NumRounds = 10;

   logic [63:0]        key_hi_ff, key_lo_ff;
   logic [127:0]       cipher_key;
   logic               load_valid_ff;
   aes_pkg::stage_type load_data_ff;

   logic               chain_valid [0:NumRounds];
   logic               chain_ready [0:NumRounds];
   aes_pkg::stage_type chain_data  [0:NumRounds];

   // Key registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_hi_ff <= '0;
         key_lo_ff <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            aes_pkg::CSR_KEY_HI: key_hi_ff <= csr_wdata;
            aes_pkg::CSR_KEY_LO: key_lo_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cipher_key = {key_hi_ff, key_lo_ff};

   // Load cell: initial AddRoundKey, attach the cipher key and first round constant
   assign req_tready = !load_valid_ff || chain_ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         load_valid_ff <= 1'b0;
      end else if (req_tready) begin
         load_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         load_data_ff.state <= {req_tdata[63:0], req_tdata[127:64]} ^ cipher_key;
         load_data_ff.rkey  <= cipher_key;
         load_data_ff.rcon  <= aes_pkg::RCON_FIRST;
      end
   end

   assign chain_valid[0] = load_valid_ff;
   assign chain_data[0]  = load_data_ff;

   // Round cells
   for (genvar g = 0; g < NumRounds; g++) begin : g_round
      aes_round_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (chain_valid[g]),
         .up_ready (chain_ready[g]),
         .up_data  (chain_data[g]),
         .dn_valid (chain_valid[g + 1]),
         .dn_ready (chain_ready[g + 1]),
         .dn_data  (chain_data[g + 1])
      );
   end

   // Last cell doubles as the output register
   assign chain_ready[NumRounds] = rsp_tready;
   assign rsp_tvalid = chain_valid[NumRounds];
   assign rsp_tdata  = {chain_data[NumRounds].state[63:0], chain_data[NumRounds].state[127:64]};

endmodule

`default_nettype wire

### rtl/aes_round_cell.sv
// One cipher round cell: registers a block and its round key, runs one AES round.
`timescale 1ns / 1ps
`default_nettype none

module aes_round_cell (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    up_valid,
   output logic                   up_ready,
   input  wire aes_pkg::stage_type up_data,
   output logic                   dn_valid,
   input  wire                    dn_ready,
   output aes_pkg::stage_type     dn_data
);

   logic               valid_ff, valid_in;
   aes_pkg::stage_type data_ff, data_in;
   logic [127:0]       shifted, mixed, key_next;

   // Take a new transaction when empty or when the neighbor drains this one
   assign up_ready = !valid_ff || dn_ready;

   // Round datapath: the final round skips MixColumns
   always_comb begin
      shifted  = aes_pkg::sub_shift(up_data.state);
      mixed    = (up_data.rcon == aes_pkg::RCON_LAST) ? shifted : aes_pkg::mix_cols(shifted);
      key_next = aes_pkg::next_key(up_data.rkey, up_data.rcon);
      data_in.state = mixed ^ key_next;
      data_in.rkey  = key_next;
      data_in.rcon  = aes_pkg::xtime(up_data.rcon);
   end

   assign valid_in = up_ready ? up_valid : valid_ff;

   // Control register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload register: load on accept, hold otherwise
   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

`default_nettype wire
